// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; every check is clocked on clk and
// held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define GDW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GDW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/gdw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_pkg
// Shared types, codes and defaults of the graph walk block.
// ----------------------------------------------------------------------------
package gdw_pkg;

    localparam int GDW_MAX_VERTICES = 64;
    localparam int GDW_EDGE_SLOTS   = 512;
    localparam int GDW_STACK_DEPTH  = 128;

    localparam int IDX_W   = 6;
    localparam int LABEL_W = 8;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        CMD_SET_LABEL = 2'd0,
        CMD_ADD_EDGE  = 2'd1,
        CMD_WALK      = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNKNOWN   = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_START = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_LA_RD,
        S_LA_WR,
        S_LB_RD,
        S_LB_WR,
        S_RESP,
        S_POP,
        S_POP_D,
        S_VIS,
        S_EDGE,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [IDX_W-1:0]   vertex_index;
        logic [LABEL_W-1:0] label_a;
        logic [LABEL_W-1:0] label_b;
    } req_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]   visit_index;
        logic [LABEL_W-1:0] visit_label;
        logic               last;
        logic [2:0]         status;
    } rsp_word_t;

    typedef logic [COUNT_W-1:0] cfg_word_t;

endpackage

// File: hdl/gdw_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_chan_if
// Valid/ready channel carrying one word of a chosen payload type.
// ----------------------------------------------------------------------------
interface gdw_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/gdw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_ram
// Simple dual-port synchronous RAM: one write, one read, registered read
// data that holds until the next read.
// ----------------------------------------------------------------------------
module gdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/gdw_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdw_outbuf
// One-word output register between the walk engine and the result channel.
// ----------------------------------------------------------------------------
module gdw_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gdw_pkg::rsp_word_t  word,
    output logic                free,
    gdw_chan_if.source          rsp
);

    logic               valid_reg;
    logic               valid_next;
    gdw_pkg::rsp_word_t word_reg;

    // room when empty or when the held word leaves this cycle
    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // load payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            word_reg <= word;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.data  = word_reg;

endmodule

// File: hdl/graph_dfs_walk_iterative.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dfs_walk_iterative
// Stores an undirected labelled graph and walks it depth first.
// ----------------------------------------------------------------------------
// Commands are taken one at a time. Set label and clear edges are handled in
// the idle state. Add edge scans the label RAM one vertex at a time until both
// labels are found or the effective vertex count is used up, links both entries
// unless a label is missing or the edge store is full, and then emits its
// status; with no live vertex the status follows directly. A walk pops, checks
// and visits each new vertex, pops and checks an already visited one, and reads
// the neighbor entries from the edge RAM one after another; the single read port
// of the stack and edge RAMs serializes these steps. A result waiting in the
// output register does not block the next command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module graph_dfs_walk_iterative #(
    parameter int MAX_VERTICES = gdw_pkg::GDW_MAX_VERTICES,
    parameter int EDGE_SLOTS   = gdw_pkg::GDW_EDGE_SLOTS,
    parameter int STACK_DEPTH  = gdw_pkg::GDW_STACK_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    gdw_chan_if.sink   req,
    gdw_chan_if.source rsp,
    gdw_chan_if.sink   cfg
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW = $clog2(EDGE_SLOTS);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = gdw_pkg::COUNT_W;
    localparam int LW = gdw_pkg::LABEL_W;
    localparam int XW = VW + EW + 1;
    localparam logic [CW-1:0] MAXV = CW'(MAX_VERTICES);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    gdw_pkg::state_t      state_reg, state_next;
    logic [CW-1:0]        vcount_reg, vcount_next;
    logic [LW-1:0]        la_reg, la_next;
    logic [LW-1:0]        lb_reg, lb_next;
    logic                 fa_reg, fa_next;
    logic                 fb_reg, fb_next;
    logic [VW-1:0]        a_reg, a_next;
    logic [VW-1:0]        b_reg, b_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [EW:0]          fill_reg, fill_next;
    logic [MAX_VERTICES-1:0] hok_reg, hok_next;
    logic [MAX_VERTICES-1:0] vis_reg, vis_next;
    logic [SW:0]          level_reg, level_next;
    logic                 ovf_reg, ovf_next;
    logic [VW-1:0]        k_reg, k_next;
    logic [VW-1:0]        pidx_reg, pidx_next;
    logic [LW-1:0]        plab_reg, plab_next;
    logic                 pval_reg, pval_next;
    gdw_pkg::status_t     st_reg, st_next;

    // ------------------------------------------------------------------
    // memory ports
    // ------------------------------------------------------------------
    logic          lab_we, lab_re;
    logic [VW-1:0] lab_waddr, lab_raddr;
    logic [LW-1:0] lab_rdata;
    logic          hd_we, hd_re;
    logic [VW-1:0] hd_waddr, hd_raddr;
    logic [EW-1:0] hd_wdata, hd_rdata;
    logic          ed_we, ed_re;
    logic [EW-1:0] ed_waddr, ed_raddr;
    logic [XW-1:0] ed_wdata, ed_rdata;
    logic          st_we, st_re;
    logic [SW-1:0] st_waddr, st_raddr;
    logic [VW-1:0] st_wdata, st_rdata;

    logic               obuf_push, obuf_free;
    gdw_pkg::rsp_word_t obuf_word;

    logic          accept;
    logic [CW-1:0] live;
    logic          ma, mb;
    logic [CW:0]   cnt_inc;
    logic [VW-1:0] ed_tgt;
    logic [EW-1:0] ed_nxt;
    logic          ed_nok;

    gdw_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES), .AW(VW)) u_labels (
        .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(la_next),
        .re(lab_re), .raddr(lab_raddr), .rdata(lab_rdata)
    );

    gdw_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES), .AW(VW)) u_heads (
        .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .re(hd_re), .raddr(hd_raddr), .rdata(hd_rdata)
    );

    gdw_ram #(.WIDTH(XW), .DEPTH(EDGE_SLOTS), .AW(EW)) u_edges (
        .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
        .re(ed_re), .raddr(ed_raddr), .rdata(ed_rdata)
    );

    gdw_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH), .AW(SW)) u_stack (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
    );

    gdw_outbuf u_outbuf (
        .clk(clk), .rst_n(rst_n), .push(obuf_push), .word(obuf_word),
        .free(obuf_free), .rsp(rsp)
    );

    // configuration register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
        end
        else
        begin
            vcount_reg <= vcount_next;
        end
    end

    assign vcount_next = (cfg.valid) ? cfg.data : vcount_reg;

    // effective vertex count
    assign live    = (vcount_reg < MAXV) ? vcount_reg : MAXV;
    assign req.ready = (state_reg == gdw_pkg::S_IDLE);
    assign accept  = req.valid && req.ready;
    assign cnt_inc = {1'b0, cnt_reg} + (CW+1)'(1);
    assign ma      = !fa_reg && (lab_rdata == la_reg);
    assign mb      = !fb_reg && (lab_rdata == lb_reg);
    assign ed_tgt  = ed_rdata[XW-1 -: VW];
    assign ed_nxt  = ed_rdata[EW:1];
    assign ed_nok  = ed_rdata[0];

    // ------------------------------------------------------------------
    // next state and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        la_next    = la_reg;
        lb_next    = lb_reg;
        fa_next    = fa_reg;
        fb_next    = fb_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        hok_next   = hok_reg;
        vis_next   = vis_reg;
        level_next = level_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        pidx_next  = pidx_reg;
        plab_next  = plab_reg;
        pval_next  = pval_reg;
        st_next    = st_reg;

        lab_we = 1'b0; lab_waddr = '0; lab_re = 1'b0; lab_raddr = '0;
        hd_we  = 1'b0; hd_waddr  = '0; hd_wdata = '0; hd_re = 1'b0; hd_raddr = '0;
        ed_we  = 1'b0; ed_waddr  = '0; ed_wdata = '0; ed_re = 1'b0; ed_raddr = '0;
        st_we  = 1'b0; st_waddr  = '0; st_wdata = '0; st_re = 1'b0; st_raddr = '0;

        obuf_push = 1'b0;
        obuf_word = '0;

        case (state_reg)
            gdw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    la_next = req.data.label_a;
                    lb_next = req.data.label_b;
                    case (gdw_pkg::cmd_t'(req.data.command))
                        gdw_pkg::CMD_SET_LABEL:
                        begin
                            // drop writes beyond the label RAM
                            if (32'(req.data.vertex_index) < MAX_VERTICES)
                            begin
                                lab_we    = 1'b1;
                                lab_waddr = VW'(req.data.vertex_index);
                            end
                        end
                        gdw_pkg::CMD_CLEAR:
                        begin
                            fill_next = '0;
                            hok_next  = '0;
                        end
                        gdw_pkg::CMD_ADD_EDGE:
                        begin
                            fa_next  = 1'b0;
                            fb_next  = 1'b0;
                            cnt_next = '0;
                            if (live == '0)
                            begin
                                st_next    = gdw_pkg::ST_UNKNOWN;
                                state_next = gdw_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = gdw_pkg::S_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            if ({1'b0, req.data.vertex_index} >= live)
                            begin
                                st_next    = gdw_pkg::ST_BAD_START;
                                state_next = gdw_pkg::S_RESP;
                            end
                            else
                            begin
                                // seed the stack with the start vertex
                                vis_next   = '0;
                                st_we      = 1'b1;
                                st_waddr   = '0;
                                st_wdata   = VW'(req.data.vertex_index);
                                level_next = (SW+1)'(1);
                                ovf_next   = 1'b0;
                                pval_next  = 1'b0;
                                state_next = gdw_pkg::S_POP;
                            end
                        end
                    endcase
                end
            end

            gdw_pkg::S_SRCH_RD:
            begin
                lab_re     = 1'b1;
                lab_raddr  = cnt_reg[VW-1:0];
                state_next = gdw_pkg::S_SRCH_CMP;
            end

            gdw_pkg::S_SRCH_CMP:
            begin
                // keep the lowest matching index for each label
                if (ma)
                begin
                    fa_next = 1'b1;
                    a_next  = cnt_reg[VW-1:0];
                end
                if (mb)
                begin
                    fb_next = 1'b1;
                    b_next  = cnt_reg[VW-1:0];
                end
                cnt_next = cnt_inc[CW-1:0];
                if ((fa_next && fb_next) || (cnt_inc >= {1'b0, live}))
                begin
                    if (!(fa_next && fb_next))
                    begin
                        st_next    = gdw_pkg::ST_UNKNOWN;
                        state_next = gdw_pkg::S_RESP;
                    end
                    else if (32'(fill_reg) + 2 > EDGE_SLOTS)
                    begin
                        st_next    = gdw_pkg::ST_FULL;
                        state_next = gdw_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = gdw_pkg::S_LA_RD;
                    end
                end
                else
                begin
                    state_next = gdw_pkg::S_SRCH_RD;
                end
            end

            gdw_pkg::S_LA_RD:
            begin
                hd_re      = 1'b1;
                hd_raddr   = a_reg;
                state_next = gdw_pkg::S_LA_WR;
            end

            gdw_pkg::S_LA_WR:
            begin
                // insert entry toward b at the head of a's list
                ed_we          = 1'b1;
                ed_waddr       = fill_reg[EW-1:0];
                ed_wdata       = {b_reg, hd_rdata, hok_reg[a_reg]};
                hd_we          = 1'b1;
                hd_waddr       = a_reg;
                hd_wdata       = fill_reg[EW-1:0];
                hok_next[a_reg] = 1'b1;
                fill_next      = fill_reg + (EW+1)'(1);
                state_next     = gdw_pkg::S_LB_RD;
            end

            gdw_pkg::S_LB_RD:
            begin
                hd_re      = 1'b1;
                hd_raddr   = b_reg;
                state_next = gdw_pkg::S_LB_WR;
            end

            gdw_pkg::S_LB_WR:
            begin
                // insert entry toward a at the head of b's list
                ed_we          = 1'b1;
                ed_waddr       = fill_reg[EW-1:0];
                ed_wdata       = {a_reg, hd_rdata, hok_reg[b_reg]};
                hd_we          = 1'b1;
                hd_waddr       = b_reg;
                hd_wdata       = fill_reg[EW-1:0];
                hok_next[b_reg] = 1'b1;
                fill_next      = fill_reg + (EW+1)'(1);
                st_next        = gdw_pkg::ST_OK;
                state_next     = gdw_pkg::S_RESP;
            end

            gdw_pkg::S_RESP:
            begin
                if (obuf_free)
                begin
                    obuf_push        = 1'b1;
                    obuf_word.last   = 1'b1;
                    obuf_word.status = st_reg;
                    state_next       = gdw_pkg::S_IDLE;
                end
            end

            gdw_pkg::S_POP:
            begin
                if (level_reg == '0)
                begin
                    state_next = gdw_pkg::S_FIN;
                end
                else
                begin
                    level_next = level_reg - (SW+1)'(1);
                    st_re      = 1'b1;
                    st_raddr   = level_next[SW-1:0];
                    state_next = gdw_pkg::S_POP_D;
                end
            end

            gdw_pkg::S_POP_D:
            begin
                if (vis_reg[st_rdata])
                begin
                    state_next = gdw_pkg::S_POP;
                end
                else
                begin
                    vis_next[st_rdata] = 1'b1;
                    k_next     = st_rdata;
                    lab_re     = 1'b1;
                    lab_raddr  = st_rdata;
                    hd_re      = 1'b1;
                    hd_raddr   = st_rdata;
                    state_next = gdw_pkg::S_VIS;
                end
            end

            gdw_pkg::S_VIS:
            begin
                // flush the previous visit, then hold this one back
                if (!pval_reg || obuf_free)
                begin
                    if (pval_reg)
                    begin
                        obuf_push             = 1'b1;
                        obuf_word.visit_index = gdw_pkg::IDX_W'(pidx_reg);
                        obuf_word.visit_label = plab_reg;
                        obuf_word.status      = gdw_pkg::ST_OK;
                    end
                    pidx_next = k_reg;
                    plab_next = lab_rdata;
                    pval_next = 1'b1;
                    if (hok_reg[k_reg])
                    begin
                        ed_re      = 1'b1;
                        ed_raddr   = hd_rdata;
                        state_next = gdw_pkg::S_EDGE;
                    end
                    else
                    begin
                        state_next = gdw_pkg::S_POP;
                    end
                end
            end

            gdw_pkg::S_EDGE:
            begin
                // push an unvisited neighbor, flag a full stack
                if (!vis_reg[ed_tgt])
                begin
                    if (32'(level_reg) >= STACK_DEPTH)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        st_we      = 1'b1;
                        st_waddr   = level_reg[SW-1:0];
                        st_wdata   = ed_tgt;
                        level_next = level_reg + (SW+1)'(1);
                    end
                end
                if (ed_nok)
                begin
                    ed_re    = 1'b1;
                    ed_raddr = ed_nxt;
                end
                else
                begin
                    state_next = gdw_pkg::S_POP;
                end
            end

            gdw_pkg::S_FIN:
            begin
                if (obuf_free)
                begin
                    obuf_push             = 1'b1;
                    obuf_word.visit_index = gdw_pkg::IDX_W'(pidx_reg);
                    obuf_word.visit_label = plab_reg;
                    obuf_word.last        = 1'b1;
                    obuf_word.status      = ovf_reg ? gdw_pkg::ST_OVERFLOW
                                                    : gdw_pkg::ST_OK;
                    pval_next             = 1'b0;
                    state_next            = gdw_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = gdw_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdw_pkg::S_IDLE;
            fill_reg  <= '0;
            hok_reg   <= '0;
            vis_reg   <= '0;
            level_reg <= '0;
            ovf_reg   <= 1'b0;
            pval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            hok_reg   <= hok_next;
            vis_reg   <= vis_next;
            level_reg <= level_next;
            ovf_reg   <= ovf_next;
            pval_reg  <= pval_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        la_reg   <= la_next;
        lb_reg   <= lb_next;
        fa_reg   <= fa_next;
        fb_reg   <= fb_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        pidx_reg <= pidx_next;
        plab_reg <= plab_next;
        st_reg   <= st_next;
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `GDW_ASSERT_NOW(a_level_bound, 1'b1, 32'(level_reg) <= STACK_DEPTH, "stack level past depth")
    `GDW_ASSERT_NOW(a_fill_bound, 1'b1, 32'(fill_reg) <= EDGE_SLOTS, "edge fill past store")
    `GDW_ASSERT_NOW(a_push_room, obuf_push, obuf_free, "result pushed into a full register")
    `GDW_ASSERT_NEXT(a_mark_set, (state_reg == gdw_pkg::S_POP_D) && !vis_reg[st_rdata], vis_reg[k_reg], "popped vertex not marked")
    `GDW_ASSERT_NOW(a_fin_pending, state_reg == gdw_pkg::S_FIN, pval_reg, "walk ends with no visit held")

endmodule
